/* hdl/point_set_covariance_2d_macros.svh */
// Assertion macros for the point set covariance block.
`ifndef POINT_SET_COVARIANCE_2D_MACROS_SVH
`define POINT_SET_COVARIANCE_2D_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked while out of reset
`define PSC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("point_set_covariance_2d: same-cycle check failed");

// Next-cycle implication, checked while out of reset
`define PSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("point_set_covariance_2d: next-cycle check failed");

`else

`define PSC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PSC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hdl/psc_pkg.sv */
// Shared types and constants for the point set covariance block.
package psc_pkg;

   localparam int COORD_W    = 24;   // coordinate and center width
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SUM_W      = 62;   // accumulator width, wraps
   localparam int SQ_W       = 49;   // cov_xx, cov_yy
   localparam int XY_W       = 50;   // cov_xy
   localparam int CNT_OUT_W  = 13;   // point_count field
   localparam int REQ_DATA_W = 2 * COORD_W;
   localparam int RSP_BITS   = 2 * SQ_W + XY_W + CNT_OUT_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int CSR_IDX_W  = 1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CENTER_X = 1'b0,
      REG_CENTER_Y = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_START,
      ST_DIVIDE,
      ST_LOAD
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;    // input side open
      logic start;     // snapshot sums, start division, clear accumulators
      logic load_out;  // move quotients into the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_acc;  // last item of a contour is being accumulated
      logic div_busy;  // division in progress
   } status_type;

endpackage

/* hdl/point_set_covariance_2d.sv */
// Top level of the 2D point set covariance block.
//
// Points of a contour enter on the req_ stream, one item per cycle while
// req_tready is high. req_tdata carries point_x and point_y, req_tlast marks
// the final point of a contour. Each point is offset from the center set
// through the csr_ write port and its squared and cross terms are summed.
// The point that carries req_tlast closes the contour: req_tready drops, the
// three-stage accumulate pipe drains, and three restoring dividers work out
// the sums over the point count, one quotient bit per cycle. The result item
// appears on rsp_ and req_tready rises again once the result register is
// loaded. Ordinary points run at one per cycle while req_tready is high;
// each contour also spends time on its drain, division and result load.
// Points past MAX_POINTS are dropped and the result's overflow bit is set.
// The result register holds while rsp_tready is low; a following contour
// may stream in and be divided meanwhile, and its result waits for that
// register with req_tready low.
// Reset clears the center, the sums, the count and all valid flags.
// Centers must be written only while the block is idle; it is not enforced.
`include "point_set_covariance_2d_macros.svh"

module point_set_covariance_2d
   import psc_pkg::*;
#(
   parameter int MAX_POINTS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // point_x [23:0], point_y [47:24]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cov_xx [48:0], cov_xy [98:49], cov_yy [147:99], point_count [160:148],
   // overflow [161], zero fill [167:162]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       in_valid;

   assign req_tready = cmd.accept;
   assign in_valid   = req_tvalid & cmd.accept;

   psc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(in_valid), .in_last(req_tlast),
      .status(status), .cmd(cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready)
   );

   psc_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
      .clock(clock), .reset(reset),
      .cmd(cmd), .status(status),
      .in_valid(in_valid), .in_data(req_tdata), .in_last(req_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .out_data(rsp_tdata)
   );

   // no input is taken while a contour is being divided
   `PSC_ASSERT_NOW(a_no_accept_in_divide, clock, reset, status.div_busy, !req_tready)
   // a result is never loaded while the dividers still run
   `PSC_ASSERT_NOW(a_load_after_divide, clock, reset, cmd.load_out, !status.div_busy)
   // starting a division makes the dividers busy
   `PSC_ASSERT_NEXT(a_start_busy, clock, reset, cmd.start, status.div_busy)

endmodule

/* hdl/psc_divider.sv */
// Restoring divider lane: one quotient bit per cycle.
module psc_divider
   import psc_pkg::*;
#(
   parameter int NUM_W = 62,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot,
   output logic             busy
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [DEN_W:0]    trial;
   logic              fits;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[DEN_W-1:0];
         end
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         busy_in = (step_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quot = quo_ff;
   assign busy = busy_ff;

endmodule

/* hdl/psc_datapath.sv */
// Datapath: center offset, products, accumulators, dividers and result register.
module psc_datapath
   import psc_pkg::*;
#(
   parameter int MAX_POINTS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  in_valid,
   input  logic [REQ_DATA_W-1:0] in_data,
   input  logic                  in_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_wdata,
   output logic [RSP_DATA_W-1:0] out_data
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   logic [COORD_W-1:0] center_x_ff, center_y_ff;

   logic                     s1_valid_ff, s1_last_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, dx_in, dy_in;

   logic                     s2_valid_ff, s2_last_ff;
   logic signed [PROD_W-1:0] s2_pxx_ff, s2_pxy_ff, s2_pyy_ff;
   logic signed [PROD_W-1:0] pxx_in, pxy_in, pyy_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_xx_ff, sum_xx_in, sum_xy_ff, sum_xy_in, sum_yy_ff, sum_yy_in;
   logic             dropped_ff, dropped_in;

   logic [CNT_W-1:0] hold_count_ff;
   logic             hold_ovf_ff, hold_neg_ff, hold_zero_ff;

   logic [SUM_W-1:0] mag_xy, q_xx, q_xy, q_yy, q_xy_signed;
   logic             busy_xx, busy_xy, busy_yy;
   logic [CNT_W+CNT_OUT_W-1:0] count_ext;
   logic [RSP_DATA_W-1:0]      out_data_ff, out_data_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_CENTER_X: center_x_ff <= csr_wdata;
            REG_CENTER_Y: center_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: offsets from the center
   assign dx_in = signed'({in_data[COORD_W-1], in_data[COORD_W-1:0]})
                - signed'({center_x_ff[COORD_W-1], center_x_ff});
   assign dy_in = signed'({in_data[REQ_DATA_W-1], in_data[REQ_DATA_W-1:COORD_W]})
                - signed'({center_y_ff[COORD_W-1], center_y_ff});

   // stage 2: products, one multiplier per term
   assign pxx_in = s1_dx_ff * s1_dx_ff;
   assign pxy_in = s1_dx_ff * s1_dy_ff;
   assign pyy_in = s1_dy_ff * s1_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s1_last_ff  <= in_valid & in_last;
         s2_valid_ff <= s1_valid_ff;
         s2_last_ff  <= s1_last_ff;
      end
      s1_dx_ff  <= dx_in;
      s1_dy_ff  <= dy_in;
      s2_pxx_ff <= pxx_in;
      s2_pxy_ff <= pxy_in;
      s2_pyy_ff <= pyy_in;
   end

   // stage 3: accumulate, or drop once the count is full
   always_comb begin
      count_in   = count_ff;
      sum_xx_in  = sum_xx_ff;
      sum_xy_in  = sum_xy_ff;
      sum_yy_in  = sum_yy_ff;
      dropped_in = dropped_ff;
      if (cmd.start) begin
         count_in   = '0;
         sum_xx_in  = '0;
         sum_xy_in  = '0;
         sum_yy_in  = '0;
         dropped_in = 1'b0;
      end else if (s2_valid_ff) begin
         if (count_ff < CNT_W'(MAX_POINTS)) begin
            count_in  = count_ff + CNT_W'(1);
            sum_xx_in = sum_xx_ff + SUM_W'(s2_pxx_ff);
            sum_xy_in = sum_xy_ff + {{(SUM_W-PROD_W){s2_pxy_ff[PROD_W-1]}}, s2_pxy_ff};
            sum_yy_in = sum_yy_ff + SUM_W'(s2_pyy_ff);
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sum_xx_ff  <= '0;
         sum_xy_ff  <= '0;
         sum_yy_ff  <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         sum_xx_ff  <= sum_xx_in;
         sum_xy_ff  <= sum_xy_in;
         sum_yy_ff  <= sum_yy_in;
         dropped_ff <= dropped_in;
      end
   end

   // cross term is divided as a magnitude so the quotient truncates toward zero
   assign mag_xy = sum_xy_ff[SUM_W-1] ? (SUM_W'(0) - sum_xy_ff) : sum_xy_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hold_count_ff <= count_ff;
         hold_ovf_ff   <= dropped_ff;
         hold_neg_ff   <= sum_xy_ff[SUM_W-1];
         hold_zero_ff  <= (count_ff == '0);
      end
   end

   psc_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_xx (
      .clock(clock), .reset(reset), .start(cmd.start),
      .num(sum_xx_ff), .den(count_ff), .quot(q_xx), .busy(busy_xx)
   );

   psc_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_xy (
      .clock(clock), .reset(reset), .start(cmd.start),
      .num(mag_xy), .den(count_ff), .quot(q_xy), .busy(busy_xy)
   );

   psc_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_yy (
      .clock(clock), .reset(reset), .start(cmd.start),
      .num(sum_yy_ff), .den(count_ff), .quot(q_yy), .busy(busy_yy)
   );

   // result register
   assign q_xy_signed = hold_neg_ff ? (SUM_W'(0) - q_xy) : q_xy;
   assign count_ext   = {{CNT_OUT_W{1'b0}}, hold_count_ff};

   always_comb begin
      out_data_in = '0;
      if (!hold_zero_ff) begin
         out_data_in[SQ_W-1:0]                  = q_xx[SQ_W-1:0];
         out_data_in[SQ_W+XY_W-1:SQ_W]          = q_xy_signed[XY_W-1:0];
         out_data_in[2*SQ_W+XY_W-1:SQ_W+XY_W]   = q_yy[SQ_W-1:0];
      end
      out_data_in[RSP_BITS-2:2*SQ_W+XY_W] = count_ext[CNT_OUT_W-1:0];
      out_data_in[RSP_BITS-1]             = hold_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_data        = out_data_ff;
   assign status.last_acc = s2_valid_ff & s2_last_ff;
   assign status.div_busy = busy_xx | busy_xy | busy_yy;

endmodule

/* hdl/psc_ctrl.sv */
// Controller: input gating, drain, division and result handoff sequencing.
module psc_ctrl
   import psc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic       in_last,
   input  status_type status,
   output cmd_type    cmd,
   output logic       out_valid,
   input  logic       out_ready
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      out_valid_in = out_valid_ff & ~out_ready;
      case (state_ff)
         ST_ACCUM: begin
            cmd.accept = 1'b1;
            if (in_valid && in_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.last_acc) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // wait for the previous result to be taken
            if (!out_valid_ff || out_ready) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   assign out_valid = out_valid_ff;

endmodule
